FILE: hdl/stg_pkg.sv
// Shared types and constants for the square tone generator.
// Used by stg_core and square_tone_generator; no dependencies.
`default_nettype none

package stg_pkg;

    localparam int unsigned ActionW   = 3;
    localparam int unsigned FreqW     = 19;
    localparam int unsigned DurW      = 16;
    localparam int unsigned ScaleW    = 13;
    localparam int unsigned AmpW      = 11;
    localparam int unsigned VolW      = 5;
    localparam int unsigned SampleW   = 16;
    localparam int unsigned PhaseW    = 32;
    localparam int unsigned FramesW   = 17;
    localparam int unsigned TickW     = 32;
    localparam int unsigned MagW      = VolW + AmpW;

    localparam logic [VolW-1:0]    VolumeMax  = VolW'(20);
    localparam logic [ScaleW-1:0]  ScaleReset = ScaleW'(6087);
    localparam logic [AmpW-1:0]    AmpReset   = AmpW'(500);
    localparam logic [MagW-1:0]    PosLimit   = MagW'(32767);
    localparam logic [MagW-1:0]    NegLimit   = MagW'(32768);

    // APB register map, one 32-bit word per register
    localparam int unsigned AddrW = 3;
    localparam logic RegPhaseScale = 1'b0;
    localparam logic RegAmpStep    = 1'b1;

    typedef enum logic [ActionW-1:0] {
        ACT_SAMPLE   = 3'd0,
        ACT_TICK     = 3'd1,
        ACT_PLAY     = 3'd2,
        ACT_STOP     = 3'd3,
        ACT_VOL_DOWN = 3'd4,
        ACT_VOL_UP   = 3'd5,
        ACT_MUTE     = 3'd6
    } t_action;

    typedef struct packed {
        logic               is_muted;
        logic [VolW-1:0]    volume_level;
        logic [TickW-1:0]   frame_count;
        logic               tone_on;
        logic [SampleW-1:0] sample;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/stg_core.sv
// Tone state and per-beat result logic: phase accumulator, frame timer,
// volume and mute. Depends on stg_pkg.
`default_nettype none

module stg_core
    import stg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [ActionW-1:0] i_action,
    input  wire logic [FreqW-1:0]   i_freq_q4,
    input  wire logic [DurW-1:0]    i_duration_frames,
    input  wire logic [ScaleW-1:0]  i_phase_scale,
    input  wire logic [AmpW-1:0]    i_amplitude_step,
    output t_result                 o_result
);

    logic               r_active,     n_active;
    logic [PhaseW-1:0]  r_phase_acc,  n_phase_acc;
    logic [PhaseW-1:0]  r_phase_inc,  n_phase_inc;
    logic [FramesW-1:0] r_frames_left, n_frames_left;
    logic [TickW-1:0]   r_tick_count, n_tick_count;
    logic [VolW-1:0]    r_volume,     n_volume;
    logic               r_mute,       n_mute;

    logic [MagW-1:0]    mag;
    logic [SampleW-1:0] tone_sample;
    logic [SampleW-1:0] n_sample;
    logic [FramesW-1:0] frames_dec;
    logic [DurW-1:0]    dur_min;

    // square wave level: sign from the phase MSB, magnitude clipped to 16 bits
    always_comb begin
        mag = MagW'(r_volume) * MagW'(i_amplitude_step);
        if (!r_phase_acc[PhaseW-1]) begin
            tone_sample = (mag > PosLimit) ? PosLimit[SampleW-1:0] : mag[SampleW-1:0];
        end else begin
            tone_sample = (mag > NegLimit) ? NegLimit[SampleW-1:0]
                                           : SampleW'(SampleW'(0) - mag[SampleW-1:0]);
        end
    end

    assign frames_dec = r_frames_left - FramesW'(1);
    assign dur_min    = (i_duration_frames == '0) ? DurW'(1) : i_duration_frames;

    always_comb begin
        n_active      = r_active;
        n_phase_acc   = r_phase_acc;
        n_phase_inc   = r_phase_inc;
        n_frames_left = r_frames_left;
        n_tick_count  = r_tick_count;
        n_volume      = r_volume;
        n_mute        = r_mute;
        n_sample      = '0;
        unique case (i_action)
            ACT_SAMPLE: begin
                if (r_active && !r_mute) begin
                    n_sample    = tone_sample;
                    n_phase_acc = r_phase_acc + r_phase_inc;
                end
            end
            ACT_TICK: begin
                n_tick_count = r_tick_count + TickW'(1);
                if (r_active) begin
                    n_frames_left = frames_dec;
                    if (frames_dec == '0) begin
                        n_active = 1'b0;
                    end
                end
            end
            ACT_PLAY: begin
                n_active    = 1'b0;
                n_phase_acc = '0;
                if (i_freq_q4 != '0) begin
                    n_phase_inc   = PhaseW'(PhaseW'(i_freq_q4) * PhaseW'(i_phase_scale));
                    n_active      = 1'b1;
                    n_frames_left = FramesW'(dur_min) + FramesW'(1);
                end
            end
            ACT_STOP: begin
                n_active = 1'b0;
            end
            ACT_VOL_DOWN: begin
                if (r_volume != '0) begin
                    n_volume = r_volume - VolW'(1);
                end
            end
            ACT_VOL_UP: begin
                if (r_volume < VolumeMax) begin
                    n_volume = r_volume + VolW'(1);
                end
            end
            ACT_MUTE: begin
                n_mute = ~r_mute;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_phase_acc   <= '0;
            r_phase_inc   <= '0;
            r_frames_left <= '0;
            r_tick_count  <= '0;
            r_volume      <= VolumeMax;
            r_mute        <= 1'b0;
        end else if (i_accept) begin
            r_active      <= n_active;
            r_phase_acc   <= n_phase_acc;
            r_phase_inc   <= n_phase_inc;
            r_frames_left <= n_frames_left;
            r_tick_count  <= n_tick_count;
            r_volume      <= n_volume;
            r_mute        <= n_mute;
        end
    end

    always_comb begin
        o_result.sample       = n_sample;
        o_result.tone_on      = n_active;
        o_result.frame_count  = n_tick_count;
        o_result.volume_level = n_volume;
        o_result.is_muted     = n_mute;
    end

endmodule

`default_nettype wire

FILE: hdl/square_tone_generator.sv
// Top level of the square tone generator: APB registers, input and output
// stream handshake with a two-entry output buffer. Depends on stg_pkg, stg_core.
//
//  Channel   Dir  Signals                      Content
//  s stream  in   i_s_tvalid/o_s_tready        tuser action, tdata freq + duration
//  m stream  out  o_m_tvalid/i_m_tready        tdata result fields
//  APB       in   psel/penable/pwrite/paddr    phase_scale @0x0, amplitude_step @0x4
//
// One beat per cycle while o_s_tready is high; each beat's result is registered,
// in the output register or, if that is held by a stall, in the skid entry. The
// output buffer holds two results, so a beat is still taken in the cycle the
// downstream first stalls; o_s_tready drops only while both entries are full.
// Reset is synchronous, active low, and restores all tone state and both registers.
`default_nettype none

module square_tone_generator
    import stg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // slave stream
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [ActionW-1:0] i_s_tuser,   // [2:0] action
    input  wire logic [39:0]        i_s_tdata,   // [18:0] freq_q4, [34:19] duration_frames
    // master stream
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [55:0]             o_m_tdata,   // [15:0] sample, [16] tone_on,
                                                 // [48:17] frame_count,
                                                 // [53:49] volume_level, [54] is_muted
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [AddrW-1:0]   paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [ScaleW-1:0] r_phase_scale;
    logic [AmpW-1:0]   r_amp_step;
    logic              cfg_write;

    logic              in_accept;
    logic              out_take;
    t_result           core_result;

    t_result           r_out;
    logic              r_out_valid;
    t_result           r_skid;
    logic              r_skid_valid;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_scale <= ScaleReset;
            r_amp_step    <= AmpReset;
        end else if (cfg_write) begin
            if (paddr[2] == RegPhaseScale) begin
                r_phase_scale <= pwdata[ScaleW-1:0];
            end else begin
                r_amp_step <= pwdata[AmpW-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == RegPhaseScale) begin
            prdata = 32'(r_phase_scale);
        end else begin
            prdata = 32'(r_amp_step);
        end
    end

    assign o_s_tready = !r_skid_valid;
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign out_take   = r_out_valid && i_m_tready;

    stg_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (in_accept),
        .i_action          (i_s_tuser),
        .i_freq_q4         (i_s_tdata[FreqW-1:0]),
        .i_duration_frames (i_s_tdata[FreqW+DurW-1:FreqW]),
        .i_phase_scale     (r_phase_scale),
        .i_amplitude_step  (r_amp_step),
        .o_result          (core_result)
    );

    // output register plus skid entry; the skid drains first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (in_accept) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_accept) begin
            if (!r_out_valid || out_take) begin
                r_out <= core_result;
            end else begin
                r_skid <= core_result;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = 56'(r_out);

endmodule

`default_nettype wire
